[rtl/core/ubh_pkg.sv]
`timescale 1ns / 1ps

package ubh_pkg;

  // field widths of the channels
  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 32;
  localparam int RBIN_W   = 8;
  localparam int RES_W    = 32;
  localparam int BIU_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // defaults for the top level parameters
  localparam int NUM_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  // register reset values
  localparam logic [SAMPLE_W-1:0] LOWER_BOUND_RST = 32'h0000_0000;
  localparam logic [SAMPLE_W-1:0] BIN_WIDTH_RST   = 32'h0001_0000;
  localparam logic [BIU_W-1:0]    BINS_IN_USE_RST = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // divider status back to the controller
  typedef struct packed {
    logic done;
    logic too_big;
  } div_stat_t;

endpackage

[rtl/core/ubh_in_if.sv]
`timescale 1ns / 1ps

interface ubh_in_if;
  logic                             valid;
  logic                             ready;
  logic [ubh_pkg::CMD_W-1:0]        command;
  logic signed [ubh_pkg::SAMPLE_W-1:0] sample;
  logic [ubh_pkg::RBIN_W-1:0]       read_bin;

  modport source (output valid, command, sample, read_bin, input ready);
  modport sink (input valid, command, sample, read_bin, output ready);
endinterface

[rtl/core/ubh_out_if.sv]
`timescale 1ns / 1ps

interface ubh_out_if;
  logic                       valid;
  logic                       ready;
  logic [ubh_pkg::RES_W-1:0]  bin_count;
  logic [ubh_pkg::RES_W-1:0]  event_total;
  logic                       in_range;

  modport source (output valid, bin_count, event_total, in_range, input ready);
  modport sink (input valid, bin_count, event_total, in_range, output ready);
endinterface

[rtl/core/ubh_cfg_if.sv]
`timescale 1ns / 1ps

interface ubh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ubh_pkg::CFG_IDX_W-1:0]  index;
  logic [ubh_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/ubh_div.sv]
`timescale 1ns / 1ps

// serial restoring divider, one quotient bit per cycle, only the low IW
// quotient bits are developed; a single compare flags larger quotients
module ubh_div #(
  parameter int IW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [32:0]         dividend,
  input  logic [31:0]         divisor,
  output ubh_pkg::div_stat_t  stat,
  output logic [IW-1:0]       quotient
);

  localparam int BW = 32 + IW;
  localparam int SW = $clog2(IW + 1);

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN} dstate_t;

  dstate_t       state_r, state_nxt;
  logic [32:0]   num_r, num_nxt;
  logic [31:0]   div_r, div_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] q_r, q_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic          big_r, big_nxt;

  logic [BW-1:0] num_ext;
  logic [BW-1:0] div_sh;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // quotient overflow check and one restoring step
  assign num_ext = BW'(num_r);
  assign div_sh  = {div_r, {IW{1'b0}}};
  assign trial   = {rem_r, lo_r[IW-1]};
  assign diff    = trial - {1'b0, div_r};
  assign ge      = trial >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    big_nxt   = big_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          num_nxt   = dividend;
          div_nxt   = divisor;
          state_nxt = D_CHK;
        end
      end
      D_CHK: begin
        if (num_ext >= div_sh) begin
          big_nxt   = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          // high quotient bits are zero, so the partial remainder is the top part
          big_nxt   = 1'b0;
          rem_nxt   = 32'(num_r >> IW);
          lo_nxt    = num_r[IW-1:0];
          q_nxt     = '0;
          cnt_nxt   = SW'(IW);
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? diff[31:0] : trial[31:0];
        q_nxt   = IW'({q_r, ge});
        lo_nxt  = lo_r << 1;
        cnt_nxt = cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      big_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      big_r   <= big_nxt;
    end
    num_r <= num_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.done    = done_r;
  assign stat.too_big = big_r;
  assign quotient     = q_r;

endmodule

[rtl/core/ubh_bin_ram.sv]
`timescale 1ns / 1ps

// bin count store, one write port and one registered read port
module ubh_bin_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/uniform_bin_histogram.sv]
`timescale 1ns / 1ps

// Histogram of Q16.16 samples over NUM_BINS equal-width bins with saturating
// COUNT_WIDTH-bit counters. One command is taken at a time and each gives one
// result. For an add the bin index comes from a serial restoring divider that
// develops one quotient bit per cycle after a single overflow compare, followed
// by a read-modify-write of the count memory. A sample below the bound or a zero
// width skips the divider and the memory, a quotient caught by the overflow
// compare skips the memory, and an index at or above the bins in use runs the
// full divide but skips the memory. A read goes through the registered read port
// of the memory, and a no-op goes straight to its result. A clear sweeps the
// memory one entry per cycle. A result that is not taken holds the next command
// in its last step until the output register frees up. After reset the same
// sweep runs over all NUM_BINS entries, during which no command is taken;
// configuration writes are taken at any time and must only be issued while the
// block is idle.
module uniform_bin_histogram #(
  parameter int NUM_BINS    = ubh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = ubh_pkg::COUNT_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  ubh_in_if.sink    in_ch,
  ubh_out_if.source out_ch,
  ubh_cfg_if.sink   cfg_ch
);

  localparam int IW = $clog2(NUM_BINS);
  localparam int LW = (IW + 1 > ubh_pkg::BIU_W) ? IW + 1 : ubh_pkg::BIU_W;
  localparam int RW = (IW + 1 > ubh_pkg::RBIN_W) ? IW + 1 : ubh_pkg::RBIN_W;
  localparam int CW = COUNT_WIDTH;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_DIV, S_RD, S_UPD, S_CLR, S_FIN} state_t;

  // configuration registers
  logic [31:0]               lower_bound_r;
  logic [31:0]               bin_width_r;
  logic [ubh_pkg::BIU_W-1:0] bins_in_use_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r <= ubh_pkg::LOWER_BOUND_RST;
      bin_width_r   <= ubh_pkg::BIN_WIDTH_RST;
      bins_in_use_r <= ubh_pkg::BINS_IN_USE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ubh_pkg::CFG_LOWER_BOUND: lower_bound_r <= cfg_ch.data;
        ubh_pkg::CFG_BIN_WIDTH:   bin_width_r   <= cfg_ch.data;
        ubh_pkg::CFG_BINS_IN_USE: bins_in_use_r <= cfg_ch.data[ubh_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // controller registers
  state_t            state_r, state_nxt;
  ubh_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [IW-1:0]     addr_r, addr_nxt;
  logic              rb_ok_r, rb_ok_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     event_r, event_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CW-1:0]     res_count_r, res_count_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic [31:0]       out_count_r, out_count_nxt;
  logic [31:0]       out_total_r, out_total_nxt;
  logic              out_hit_r, out_hit_nxt;

  // datapath signals
  logic                 accept;
  ubh_pkg::cmd_t        in_cmd;
  logic [32:0]          diff;
  logic                 div_start;
  ubh_pkg::div_stat_t   div_stat;
  logic [IW-1:0]        quotient;
  logic [LW-1:0]        biu_ext;
  logic [LW-1:0]        limit;
  logic                 idx_ok;
  logic [RW-1:0]        rb_ext;
  logic                 rb_ok;
  logic [CW-1:0]        rdata;
  logic [CW-1:0]        rd_inc;
  logic                 sweeping;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [CW-1:0]        mem_wdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  assign in_cmd      = ubh_pkg::cmd_t'(in_ch.command);

  // signed difference from the lower bound, 33 bits
  assign diff = {in_ch.sample[31], in_ch.sample} - {lower_bound_r[31], lower_bound_r};
  assign div_start = accept && (in_cmd == ubh_pkg::CMD_ADD) && !diff[32] &&
                     (bin_width_r != 32'd0);

  // bins in use limited to the store depth
  assign biu_ext = LW'(bins_in_use_r);
  assign limit   = (biu_ext > LW'(NUM_BINS)) ? LW'(NUM_BINS) : biu_ext;
  assign idx_ok  = !div_stat.too_big && (LW'(quotient) < limit);

  assign rb_ext = RW'(in_ch.read_bin);
  assign rb_ok  = rb_ext < RW'(NUM_BINS);

  // saturating increment of the stored count
  assign rd_inc = (rdata == {CW{1'b1}}) ? rdata : rdata + CW'(1);

  // memory write: clearing sweep or count update
  assign sweeping  = (state_r == S_INIT) || (state_r == S_CLR);
  assign mem_we    = sweeping || ((state_r == S_UPD) && (cmd_r == ubh_pkg::CMD_ADD));
  assign mem_waddr = sweeping ? ptr_r : addr_r;
  assign mem_wdata = sweeping ? '0 : rd_inc;

  ubh_div #(
    .IW(IW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (bin_width_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  ubh_bin_ram #(
    .DEPTH(NUM_BINS),
    .WIDTH(CW),
    .AW   (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    rb_ok_nxt     = rb_ok_r;
    ptr_nxt       = ptr_r;
    event_nxt     = event_r;
    res_count_nxt = res_count_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    out_total_nxt = out_total_r;
    out_hit_nxt   = out_hit_r;
    case (state_r)
      S_INIT: begin
        ptr_nxt = ptr_r + IW'(1);
        if (ptr_r == IW'(NUM_BINS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_cmd;
          res_count_nxt = '0;
          res_hit_nxt   = 1'b0;
          case (in_cmd)
            ubh_pkg::CMD_ADD: begin
              event_nxt = (event_r == {CW{1'b1}}) ? event_r : event_r + CW'(1);
              state_nxt = div_start ? S_DIV : S_FIN;
            end
            ubh_pkg::CMD_CLEAR: begin
              event_nxt = '0;
              ptr_nxt   = '0;
              state_nxt = S_CLR;
            end
            ubh_pkg::CMD_READ: begin
              addr_nxt  = rb_ext[IW-1:0];
              rb_ok_nxt = rb_ok;
              state_nxt = S_RD;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          addr_nxt  = quotient;
          state_nxt = idx_ok ? S_RD : S_FIN;
        end
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        if (cmd_r == ubh_pkg::CMD_ADD) begin
          res_count_nxt = rd_inc;
          res_hit_nxt   = 1'b1;
        end else begin
          res_count_nxt = rb_ok_r ? rdata : '0;
        end
        state_nxt = S_FIN;
      end
      S_CLR: begin
        ptr_nxt = ptr_r + IW'(1);
        if (ptr_r == IW'(NUM_BINS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // load the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = 32'(res_count_r);
          out_total_nxt = 32'(event_r);
          out_hit_nxt   = res_hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      event_r     <= '0;
      out_valid_r <= 1'b0;
      cmd_r       <= ubh_pkg::CMD_NOP;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      event_r     <= event_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
    end
    addr_r      <= addr_nxt;
    rb_ok_r     <= rb_ok_nxt;
    res_count_r <= res_count_nxt;
    res_hit_r   <= res_hit_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bin_count   = out_count_r;
  assign out_ch.event_total = out_total_r;
  assign out_ch.in_range    = out_hit_r;

endmodule
